// ----- sv/avc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// avc_pkg
// Shared types, register indexes and the colour combine function of the
// VGA attribute controller register block.
// ----------------------------------------------------------------------------
package avc_pkg;

    localparam int unsigned PAL_ENTRIES = 16;

    // Port operations.
    typedef enum logic [1:0] {
        OP_WR_3C0 = 2'd0,
        OP_RD_3C0 = 2'd1,
        OP_RD_3C1 = 2'd2,
        OP_NONE   = 2'd3
    } op_e;

    // Register indexes above the palette.
    localparam logic [4:0] IDX_MODE  = 5'h10;
    localparam logic [4:0] IDX_PLANE = 5'h12;
    localparam logic [4:0] IDX_PAN   = 5'h13;
    localparam logic [4:0] IDX_CSEL  = 5'h14;

    // Mode control bits whose change asks for a mode recheck.
    localparam logic [7:0] MODE_RECHECK_MASK = 8'h41;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_RD_WAIT = 2'd1,
        ST_SWEEP   = 2'd2
    } state_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] wdata;
    } cmd_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       color_valid;
        logic [3:0] color_entry;
        logic [7:0] color_value;
        logic       mode_recheck;
        logic       last;
    } result_t;

    // Palette memory access controls.
    typedef struct packed {
        logic       wr_en;
        logic       rd_en;
        logic [7:0] wdata;
    } pal_ctl_t;

    // Combined DAC index: bits 4-5 come from colour select when mode bit 7
    // is set, bits 6-7 always come from colour select bits 2-3.
    function automatic logic [7:0] combine_color(logic [7:0] v, logic [7:0] mode,
                                                 logic [7:0] csel);
        logic [5:0] low;
        begin
            low = mode[7] ? {csel[1:0], v[3:0]} : v[5:0];
            return {csel[3:2], low};
        end
    endfunction

endpackage
`default_nettype wire

// ----- sv/avc_palette_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// avc_palette_ram
// Palette store: one synchronous memory with a registered read port and a
// valid bit per entry so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module avc_palette_ram #(
    parameter int unsigned ENTRIES = avc_pkg::PAL_ENTRIES
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  avc_pkg::pal_ctl_t           ctl,
    input  wire  [$clog2(ENTRIES)-1:0]  addr,
    output logic [7:0]                  rdata
);
    import avc_pkg::*;

    logic [7:0]         mem_reg [ENTRIES];
    logic [7:0]         q_reg;
    logic [ENTRIES-1:0] vld_reg;
    logic               q_vld_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem_reg[addr] <= ctl.wdata;
        end
        if (ctl.rd_en)
        begin
            q_reg <= mem_reg[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            q_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                vld_reg[addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                q_vld_reg <= vld_reg[addr];
            end
        end
    end

    assign rdata = q_vld_reg ? q_reg : 8'h00;

endmodule
`default_nettype wire

// ----- sv/avc_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// avc_ctrl
// Command decode, register file and palette sequencer. Reads the palette
// memory for port 3C1 reads and walks all entries for a re-emission.
// ----------------------------------------------------------------------------
module avc_ctrl #(
    parameter int unsigned ENTRIES = avc_pkg::PAL_ENTRIES
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    input  avc_pkg::cmd_t               cmd,
    output logic                        busy,
    output logic                        done,
    output avc_pkg::result_t            result,
    output avc_pkg::pal_ctl_t           pal_ctl,
    output logic [$clog2(ENTRIES)-1:0]  pal_addr,
    input  wire  [7:0]                  pal_rdata
);
    import avc_pkg::*;

    localparam int unsigned AW = $clog2(ENTRIES);
    localparam logic [AW-1:0] CNT_LAST = AW'(ENTRIES - 1);

    state_t        state_reg, state_next;
    logic          phase_reg, phase_next;
    logic [4:0]    index_reg, index_next;
    logic [7:0]    mode_reg, mode_next;
    logic [7:0]    plane_reg, plane_next;
    logic [3:0]    pan_reg, pan_next;
    logic [7:0]    csel_reg, csel_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic          recheck_reg, recheck_next;
    logic          done_reg, done_next;
    result_t       result_reg, result_next;

    logic [7:0]    mode_diff;
    logic          mode_chk;
    logic          is_pal;

    assign mode_diff = mode_reg ^ cmd.wdata;
    assign mode_chk  = |(mode_diff & MODE_RECHECK_MASK);
    assign is_pal    = index_reg < 5'(ENTRIES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= 1'b0;
            index_reg   <= '0;
            mode_reg    <= '0;
            plane_reg   <= '0;
            pan_reg     <= '0;
            csel_reg    <= '0;
            cnt_reg     <= '0;
            recheck_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            index_reg   <= index_next;
            mode_reg    <= mode_next;
            plane_reg   <= plane_next;
            pan_reg     <= pan_next;
            csel_reg    <= csel_next;
            cnt_reg     <= cnt_next;
            recheck_reg <= recheck_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        index_next   = index_reg;
        mode_next    = mode_reg;
        plane_next   = plane_reg;
        pan_next     = pan_reg;
        csel_next    = csel_reg;
        cnt_next     = cnt_reg;
        recheck_next = recheck_reg;
        done_next    = 1'b0;
        result_next  = '0;
        pal_ctl      = '0;
        pal_addr     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    done_next        = 1'b1;
                    result_next.last = 1'b1;
                    unique case (op_e'(cmd.op))
                        OP_RD_3C0:
                        begin
                            result_next.read_data = {3'b000, index_reg};
                        end
                        OP_RD_3C1:
                        begin
                            if (is_pal)
                            begin
                                pal_ctl.rd_en = 1'b1;
                                pal_addr      = index_reg[AW-1:0];
                                done_next     = 1'b0;
                                state_next    = ST_RD_WAIT;
                            end
                            else
                            begin
                                unique case (index_reg)
                                    IDX_MODE:  result_next.read_data = mode_reg;
                                    IDX_PLANE: result_next.read_data = plane_reg;
                                    IDX_PAN:   result_next.read_data = {4'h0, pan_reg};
                                    IDX_CSEL:  result_next.read_data = csel_reg;
                                    default:   result_next.read_data = 8'h00;
                                endcase
                            end
                        end
                        OP_WR_3C0:
                        begin
                            if (!phase_reg)
                            begin
                                index_next = cmd.wdata[4:0];
                                phase_next = 1'b1;
                            end
                            else
                            begin
                                phase_next = 1'b0;
                                if (is_pal)
                                begin
                                    pal_ctl.wr_en           = 1'b1;
                                    pal_ctl.wdata           = cmd.wdata;
                                    pal_addr                = index_reg[AW-1:0];
                                    result_next.color_valid = 1'b1;
                                    result_next.color_entry = index_reg[3:0];
                                    result_next.color_value =
                                        combine_color(cmd.wdata, mode_reg, csel_reg);
                                end
                                else
                                begin
                                    unique case (index_reg)
                                        IDX_MODE:
                                        begin
                                            mode_next = cmd.wdata;
                                            if (mode_diff[7])
                                            begin
                                                recheck_next  = mode_chk;
                                                done_next     = 1'b0;
                                                cnt_next      = '0;
                                                pal_ctl.rd_en = 1'b1;
                                                state_next    = ST_SWEEP;
                                            end
                                            else
                                            begin
                                                result_next.mode_recheck = mode_chk;
                                            end
                                        end
                                        IDX_PLANE: plane_next = cmd.wdata;
                                        IDX_PAN:   pan_next   = cmd.wdata[3:0];
                                        IDX_CSEL:
                                        begin
                                            if (csel_reg != cmd.wdata)
                                            begin
                                                csel_next     = cmd.wdata;
                                                recheck_next  = 1'b0;
                                                done_next     = 1'b0;
                                                cnt_next      = '0;
                                                pal_ctl.rd_en = 1'b1;
                                                state_next    = ST_SWEEP;
                                            end
                                        end
                                        default:
                                        begin
                                        end
                                    endcase
                                end
                            end
                        end
                        OP_NONE:
                        begin
                        end
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                done_next             = 1'b1;
                result_next.read_data = pal_rdata;
                result_next.last      = 1'b1;
                state_next            = ST_IDLE;
            end
            ST_SWEEP:
            begin
                // Data for entry cnt_reg arrives now; the next entry, if any, is read meanwhile.
                done_next               = 1'b1;
                result_next.color_valid = 1'b1;
                result_next.color_entry = 4'(cnt_reg);
                result_next.color_value = combine_color(pal_rdata, mode_reg, csel_reg);
                if (cnt_reg == CNT_LAST)
                begin
                    result_next.last         = 1'b1;
                    result_next.mode_recheck = recheck_reg;
                    state_next               = ST_IDLE;
                end
                else
                begin
                    pal_ctl.rd_en = 1'b1;
                    pal_addr      = cnt_reg + 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef ASSERT_OFF
    a_sweep_emits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SWEEP |=> done_reg)
        else $error("sweep cycle without a result beat");

    a_mid_only_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !result_reg.last |-> state_reg == ST_SWEEP)
        else $error("non-final result beat outside a sweep");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && state_reg == ST_IDLE |=> done_reg || state_reg != ST_IDLE)
        else $error("accepted command produced neither a beat nor a busy phase");

    a_one_port_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(pal_ctl.wr_en && pal_ctl.rd_en))
        else $error("palette read and write in the same cycle");

    a_color_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && result_reg.color_valid |-> result_reg.read_data == 8'h00)
        else $error("colour beat carries read data");
`endif

endmodule
`default_nettype wire

// ----- sv/vga_attribute_controller.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vga_attribute_controller
// VGA attribute controller register block: index/data writes on port 3C0,
// palette and mode registers, combined DAC colour updates.
// ----------------------------------------------------------------------------
// A result beat appears in the cycle after the command is accepted, and a new
// command may be taken on the next cycle; a port 3C1 read of a palette entry
// passes through the registered memory read and ST_RD_WAIT, with busy high.
// A re-emission gives 16 beats, one palette read per cycle, and the next
// command is taken once the sweep is back in idle. Result beats cannot be
// stalled; reset clears the control registers and palette valid bits only.
module vga_attribute_controller #(
    parameter int unsigned PALETTE_ENTRIES = avc_pkg::PAL_ENTRIES
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    input  avc_pkg::cmd_t     cmd,
    output logic              busy,
    output logic              done,
    output avc_pkg::result_t  result
);
    import avc_pkg::*;

    pal_ctl_t                       pal_ctl;
    logic [$clog2(PALETTE_ENTRIES)-1:0] pal_addr;
    logic [7:0]                     pal_rdata;

    avc_ctrl #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .pal_ctl   (pal_ctl),
        .pal_addr  (pal_addr),
        .pal_rdata (pal_rdata)
    );

    avc_palette_ram #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (pal_ctl),
        .addr  (pal_addr),
        .rdata (pal_rdata)
    );

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the VGA attribute controller register block. Port
// commands go in through start/busy, and a shadow of the block's registers
// predicts every result beat. Each beat that arrives is compared field by
// field with the oldest prediction. Directed tests come first, then random
// index/data sequences under several sender idle rates.
// ----------------------------------------------------------------------------
module tb;

    import avc_pkg::*;

    localparam int          LIMIT_CYCLES = 100000;
    localparam int          DRAIN_CYCLES = 24;
    localparam int          REPORT_MAX   = 10;
    localparam logic [4:0]  IDX_OVERSCAN = 5'h11;
    localparam logic [4:0]  IDX_TOP      = 5'h1F;
    localparam int          MODE_PAL_BIT = 7;

    logic    clk;
    logic    rst_n;
    logic    start;
    cmd_t    cmd;
    logic    busy;
    logic    done;
    result_t result;

    // Shadow of the register file.
    logic       data_phase;
    logic [4:0] sel_index;
    logic [7:0] pal_shadow [PAL_ENTRIES];
    logic [7:0] mode_reg;
    logic [7:0] plane_reg;
    logic [3:0] pan_reg;
    logic [7:0] csel_reg;

    result_t awaited_beats [$];
    int      err_count;
    int      cycle_count;
    int      idle_pct;

    vga_attribute_controller u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Combined DAC index of one palette byte under the current mode and
    // colour select.
    function automatic logic [7:0] dac_index(input logic [7:0] pal);
        logic [7:0] c;
        begin
            c[7:6] = csel_reg[3:2];
            if (mode_reg[MODE_PAL_BIT])
                c[5:0] = {csel_reg[1:0], pal[3:0]};
            else
                c[5:0] = pal[5:0];
            return c;
        end
    endfunction

    // All 16 combined entries, the recheck flag on the final beat only.
    function automatic void queue_full_sweep(input logic recheck);
        result_t r;
        begin
            for (int i = 0; i < PAL_ENTRIES; i++)
            begin
                r             = '0;
                r.color_valid = 1'b1;
                r.color_entry = i[3:0];
                r.color_value = dac_index(pal_shadow[i]);
                if (i == PAL_ENTRIES - 1)
                begin
                    r.mode_recheck = recheck;
                    r.last         = 1'b1;
                end
                awaited_beats.push_back(r);
            end
        end
    endfunction

    function automatic void apply_port_access(input cmd_t c);
        result_t    r;
        logic [7:0] diff;
        begin
            r      = '0;
            r.last = 1'b1;
            case (c.op)
                OP_RD_3C0:
                    r.read_data = {3'b000, sel_index};
                OP_RD_3C1:
                begin
                    if (sel_index < PAL_ENTRIES)
                        r.read_data = pal_shadow[sel_index[3:0]];
                    else if (sel_index == IDX_MODE)
                        r.read_data = mode_reg;
                    else if (sel_index == IDX_PLANE)
                        r.read_data = plane_reg;
                    else if (sel_index == IDX_PAN)
                        r.read_data = {4'h0, pan_reg};
                    else if (sel_index == IDX_CSEL)
                        r.read_data = csel_reg;
                end
                OP_WR_3C0:
                begin
                    if (!data_phase)
                    begin
                        sel_index  = c.wdata[4:0];
                        data_phase = 1'b1;
                    end
                    else
                    begin
                        data_phase = 1'b0;
                        if (sel_index < PAL_ENTRIES)
                        begin
                            pal_shadow[sel_index[3:0]] = c.wdata;
                            r.color_valid = 1'b1;
                            r.color_entry = sel_index[3:0];
                            r.color_value = dac_index(c.wdata);
                        end
                        else if (sel_index == IDX_MODE)
                        begin
                            diff     = mode_reg ^ c.wdata;
                            mode_reg = c.wdata;
                            if (diff[MODE_PAL_BIT])
                            begin
                                queue_full_sweep(|(diff & MODE_RECHECK_MASK));
                                return;
                            end
                            r.mode_recheck = |(diff & MODE_RECHECK_MASK);
                        end
                        else if (sel_index == IDX_PLANE)
                            plane_reg = c.wdata;
                        else if (sel_index == IDX_PAN)
                            pan_reg = c.wdata[3:0];
                        else if (sel_index == IDX_CSEL && csel_reg != c.wdata)
                        begin
                            csel_reg = c.wdata;
                            queue_full_sweep(1'b0);
                            return;
                        end
                    end
                end
                default:
                    ;
            endcase
            awaited_beats.push_back(r);
        end
    endfunction

    task automatic report_bad(input string what, input result_t exp_r, input result_t got_r);
        begin
            err_count++;
            if (err_count <= REPORT_MAX)
            begin
                $display("%0t: %s", $realtime, what);
                $display("  expected rd=%h cv=%b ent=%h val=%h rc=%b last=%b",
                         exp_r.read_data, exp_r.color_valid, exp_r.color_entry,
                         exp_r.color_value, exp_r.mode_recheck, exp_r.last);
                $display("  actual   rd=%h cv=%b ent=%h val=%h rc=%b last=%b",
                         got_r.read_data, got_r.color_valid, got_r.color_entry,
                         got_r.color_value, got_r.mode_recheck, got_r.last);
            end
        end
    endtask

    // Every result beat is checked at the edge that ends its cycle.
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && done)
        begin
            if (awaited_beats.size() == 0)
                report_bad("result beat with nothing expected", '0, result);
            else
            begin
                exp_r = awaited_beats.pop_front();
                if (exp_r.read_data !== result.read_data
                    || exp_r.color_valid !== result.color_valid
                    || exp_r.color_entry !== result.color_entry
                    || exp_r.color_value !== result.color_value
                    || exp_r.mode_recheck !== result.mode_recheck
                    || exp_r.last !== result.last)
                    report_bad("result beat mismatch", exp_r, result);
            end
        end
    end

    // Drives one command and waits until the block takes it. The caller is
    // positioned after a rising edge; start stays high until the next falling
    // edge so that back-to-back commands leave no gap.
    task automatic send_cmd(input op_e op, input logic [7:0] data);
        cmd_t c;
        int   gap;
        begin
            c.op    = op;
            c.wdata = data;
            @(negedge clk);
            if ($urandom_range(0, 99) < idle_pct)
            begin
                start = 1'b0;
                gap   = $urandom_range(1, 6);
                repeat (gap) @(negedge clk);
            end
            start = 1'b1;
            cmd   = c;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            apply_port_access(c);
        end
    endtask

    task automatic write_reg(input logic [7:0] index, input logic [7:0] value);
        begin
            send_cmd(OP_WR_3C0, index);
            send_cmd(OP_WR_3C0, value);
        end
    endtask

    // Holds the sender off until every predicted beat has come back.
    task automatic drain_results;
        begin
            @(negedge clk);
            start = 1'b0;
            while (awaited_beats.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    task automatic test_reset_state;
        begin
            send_cmd(OP_RD_3C0, 8'hFF);
            send_cmd(OP_RD_3C1, 8'h00);
            send_cmd(OP_NONE, 8'hA5);
            drain_results();
        end
    endtask

    task automatic test_palette_writes;
        begin
            // Upper bits of an index write are dropped.
            write_reg(8'hE0, 8'hFF);
            write_reg(8'h0F, 8'h00);
            send_cmd(OP_WR_3C0, 8'h00);
            send_cmd(OP_RD_3C1, 8'h5A);
            drain_results();
        end
    endtask

    task automatic test_mode_control;
        begin
            // Bit 7 and a recheck bit change together: full sweep, flag on
            // the final beat.
            write_reg({3'b000, IDX_MODE}, 8'hC1);
            // Only bit 6 changes: a single beat carrying the flag.
            write_reg({3'b000, IDX_MODE}, 8'h81);
            send_cmd(OP_RD_3C1, 8'h00);
            drain_results();
        end
    endtask

    task automatic test_other_registers;
        begin
            write_reg({3'b000, IDX_PLANE}, 8'hFF);
            write_reg({3'b000, IDX_PAN}, 8'hFF);
            send_cmd(OP_RD_3C1, 8'h00);
            write_reg({3'b000, IDX_CSEL}, 8'h0F);
            // Same colour select again: nothing is re-emitted.
            write_reg({3'b000, IDX_CSEL}, 8'h0F);
            send_cmd(OP_RD_3C1, 8'h00);
            drain_results();
        end
    endtask

    task automatic test_ignored_indexes;
        begin
            send_cmd(OP_WR_3C0, {3'b111, IDX_OVERSCAN});
            // A 3C0 read between index and data leaves the phase alone.
            send_cmd(OP_RD_3C0, 8'h00);
            send_cmd(OP_WR_3C0, 8'hAA);
            send_cmd(OP_RD_3C1, 8'h00);
            write_reg({3'b000, IDX_TOP}, 8'h55);
            send_cmd(OP_RD_3C1, 8'h00);
            drain_results();
        end
    endtask

    task automatic test_random(input int n_items);
        int         sent;
        int         kind;
        int         pick;
        logic [7:0] ix;
        begin
            sent = 0;
            while (sent < n_items)
            begin
                kind  = $urandom_range(0, 99);
                pick  = $urandom_range(0, 99);
                ix    = 8'($urandom_range(0, 255));
                if (pick < 60)
                    ix[4:0] = 5'($urandom_range(0, 15));
                else if (pick < 85)
                    ix[4:0] = 5'($urandom_range(IDX_MODE, IDX_CSEL));
                else
                    ix[4:0] = 5'($urandom_range(IDX_CSEL + 1, IDX_TOP));
                if (kind < 75 && data_phase)
                begin
                    // Realign after a stray write so the sequence is well formed.
                    send_cmd(OP_WR_3C0, 8'($urandom_range(0, 255)));
                    sent++;
                end
                if (kind < 50)
                begin
                    write_reg(ix, 8'($urandom_range(0, 255)));
                    sent += 2;
                end
                else if (kind < 75)
                begin
                    send_cmd(OP_WR_3C0, ix);
                    send_cmd(OP_RD_3C1, 8'($urandom_range(0, 255)));
                    send_cmd(OP_WR_3C0, 8'($urandom_range(0, 255)));
                    sent += 3;
                end
                else
                begin
                    if (kind < 85)
                        send_cmd(OP_RD_3C0, 8'($urandom_range(0, 255)));
                    else if (kind < 93)
                        send_cmd(OP_RD_3C1, 8'($urandom_range(0, 255)));
                    else if (kind < 97)
                        send_cmd(OP_WR_3C0, 8'($urandom_range(0, 255)));
                    else
                        send_cmd(OP_NONE, 8'($urandom_range(0, 255)));
                    sent++;
                end
            end
            drain_results();
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = '0;
        err_count  = 0;
        idle_pct   = 35;
        data_phase = 1'b0;
        sel_index  = '0;
        mode_reg   = '0;
        plane_reg  = '0;
        pan_reg    = '0;
        csel_reg   = '0;
        for (int i = 0; i < PAL_ENTRIES; i++)
            pal_shadow[i] = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        test_reset_state();
        test_palette_writes();
        test_mode_control();
        test_other_registers();
        test_ignored_indexes();

        test_random(26);
        idle_pct = 66;
        test_random(26);
        idle_pct = 0;
        test_random(26);

        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/avc_pkg.sv
sv/avc_palette_ram.sv
sv/avc_ctrl.sv
sv/vga_attribute_controller.sv
tb/tb.sv
